@@ design/bf3_pkg.sv @@
`timescale 1ns / 1ps

package bf3_pkg;

  // Field widths
  localparam int CH_W        = 16;
  localparam int PIX_W       = 3 * CH_W;
  localparam int SUM_W       = 20;          // holds nine 16-bit channel values
  localparam int COORD_W     = 10;
  localparam int DIM_W       = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - 2 * COORD_W;

  // Defaults
  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int DIM_RESET       = 512;

  // Reciprocals of the neighbor counts, scaled by 2^RECIP_SH, rounded up.
  // Exact for every dividend below 2^SUM_W.
  localparam int RECIP_W  = 25;
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_W-1:0] RECIP_1 = 25'd16777216;
  localparam logic [RECIP_W-1:0] RECIP_2 = 25'd8388608;
  localparam logic [RECIP_W-1:0] RECIP_3 = 25'd5592406;
  localparam logic [RECIP_W-1:0] RECIP_4 = 25'd4194304;
  localparam logic [RECIP_W-1:0] RECIP_6 = 25'd2796203;
  localparam logic [RECIP_W-1:0] RECIP_9 = 25'd1864136;

  // Position and neighbor-inclusion flags of the pixel being averaged
  typedef struct packed {
    logic               produce;
    logic               top;
    logic               bot;
    logic               left;
    logic               right;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pos_t;

  // Channel sums waiting for the divide
  typedef struct packed {
    logic [SUM_W-1:0]   sum_r;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_b;
    logic [RECIP_W-1:0] recip;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } acc_t;

  // Reciprocal for a window of rows x cols neighbors (each 1..3)
  function automatic logic [RECIP_W-1:0] recip_of(logic [1:0] rows, logic [1:0] cols);
    logic [RECIP_W-1:0] r;
    unique case ({rows, cols})
      4'b0110, 4'b1001: r = RECIP_2;
      4'b0111, 4'b1101: r = RECIP_3;
      4'b1010:          r = RECIP_4;
      4'b1011, 4'b1110: r = RECIP_6;
      4'b1111:          r = RECIP_9;
      default:          r = RECIP_1;
    endcase
    return r;
  endfunction

endpackage

@@ design/bf3_line_buf.sv @@
`timescale 1ns / 1ps

// Two line stores (the two rows above the incoming pixel), read when an
// item is accepted and written when that item moves on into the window.
module bf3_line_buf
  import bf3_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT,
  parameter int AW      = $clog2(MAX_DIM)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_px,
  output logic [PIX_W-1:0] up_col,
  output logic [PIX_W-1:0] mid_col
);

  logic [PIX_W-1:0] upper_mem  [MAX_DIM];
  logic [PIX_W-1:0] middle_mem [MAX_DIM];
  logic [PIX_W-1:0] up_q;
  logic [PIX_W-1:0] mid_q;
  logic             fwd;
  logic [PIX_W-1:0] fwd_up;
  logic [PIX_W-1:0] fwd_mid;

  // Rows shift down one store on each write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid_col;
      middle_mem[wr_addr] <= wr_px;
    end
    if (rd_en) begin
      up_q  <= upper_mem[rd_addr];
      mid_q <= middle_mem[rd_addr];
    end
  end

  // Bypass for a read that hits the address written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_up  <= mid_col;
      fwd_mid <= wr_px;
    end
  end

  assign up_col  = fwd ? fwd_up  : up_q;
  assign mid_col = fwd ? fwd_mid : mid_q;

endmodule

@@ design/bf3_window.sv @@
`timescale 1ns / 1ps

// 3x3 window: two stored columns plus the incoming column. Sums the
// neighbors inside the frame and registers the sums with their divisor.
module bf3_window
  import bf3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             load,
  output logic             load_ready,
  input  logic [PIX_W-1:0] up_col,
  input  logic [PIX_W-1:0] mid_col,
  input  logic [PIX_W-1:0] px,
  input  pos_t             pos,
  output logic             acc_valid,
  input  logic             acc_ready,
  output acc_t             acc
);

  logic [PIX_W-1:0] win_l   [3];
  logic [PIX_W-1:0] win_c   [3];
  logic [PIX_W-1:0] new_col [3];
  logic [2:0]       row_en;
  logic [SUM_W-1:0] sum     [3];
  logic [1:0]       rows;
  logic [1:0]       cols;

  assign new_col[0] = up_col;
  assign new_col[1] = mid_col;
  assign new_col[2] = px;
  assign row_en     = {pos.bot, 1'b1, pos.top};
  assign rows       = 2'd1 + {1'b0, pos.top} + {1'b0, pos.bot};
  assign cols       = 2'd1 + {1'b0, pos.left} + {1'b0, pos.right};

  // Window columns advance by one on every item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        win_l[r] <= '0;
        win_c[r] <= '0;
      end
    end else if (shift) begin
      win_l <= win_c;
      win_c <= new_col;
    end
  end

  // Per-channel sum of the in-frame neighbors
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        if (row_en[r]) begin
          if (pos.left) begin
            sum[ch] = sum[ch] + SUM_W'(win_l[r][ch*CH_W +: CH_W]);
          end
          sum[ch] = sum[ch] + SUM_W'(win_c[r][ch*CH_W +: CH_W]);
          if (pos.right) begin
            sum[ch] = sum[ch] + SUM_W'(new_col[r][ch*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  // Sum register
  assign load_ready = !acc_valid || acc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (load) begin
      acc_valid <= 1'b1;
    end else if (acc_ready) begin
      acc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc.sum_r <= sum[0];
      acc.sum_g <= sum[1];
      acc.sum_b <= sum[2];
      acc.recip <= recip_of(rows, cols);
      acc.row   <= pos.row;
      acc.col   <= pos.col;
      acc.last  <= pos.last;
    end
  end

endmodule

@@ design/bf3_mean.sv @@
`timescale 1ns / 1ps

// Divides the sums by the neighbor count (reciprocal multiply) and holds
// the result in the output register.
module bf3_mean
  import bf3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  acc_t                   acc,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // red, green, blue, out_row, out_col
  output logic                   m_axis_tlast   // last_of_frame
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;

  assign prod_r = PROD_W'(acc.sum_r) * PROD_W'(acc.recip);
  assign prod_g = PROD_W'(acc.sum_g) * PROD_W'(acc.recip);
  assign prod_b = PROD_W'(acc.sum_b) * PROD_W'(acc.recip);

  assign in_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_valid && in_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, acc.col, acc.row,
                       prod_b[RECIP_SH +: CH_W],
                       prod_g[RECIP_SH +: CH_W],
                       prod_r[RECIP_SH +: CH_W]};
      m_axis_tlast <= acc.last;
    end
  end

endmodule

@@ design/box_filter_3x3_edge_clipped.sv @@
`timescale 1ns / 1ps

// 3x3 mean filter over a square RGB frame streamed in raster order, one
// 48-bit pixel per transaction; each result is the truncating per-channel
// mean of the neighbors inside the frame (9 inside, 6 on edges, 4 in
// corners). One item is taken every clock unless the output holds it off;
// the result for pixel (r,c) is produced by the input item one row and one
// pixel later, so after the last pixel of a frame the source sends frame_dim+1
// drain items (tuser = 1) to flush the bottom row, and the next item starts a
// new frame. The result is presented through three register stages (line
// store read, window sum, reciprocal divide). Writing frame_dim restarts the
// frame; 0 acts as 1 and values above MAX_DIM act as MAX_DIM.
// The two line stores are MAX_DIM x 48 bits each and need no initialization.
module box_filter_3x3_edge_clipped
  import bf3_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [DIM_W-1:0]       cfg_data,       // frame_dim
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]             s_axis_tuser,   // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // red, green, blue, out_row, out_col
  output logic                   m_axis_tlast    // last_of_frame
);

  localparam int AW = $clog2(MAX_DIM);
  localparam int RW = $clog2(MAX_DIM + 2);

  function automatic logic [RW-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [RW-1:0] d;
    if (v == '0) begin
      d = RW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      d = RW'(MAX_DIM);
    end else begin
      d = RW'(v);
    end
    return d;
  endfunction

  logic [RW-1:0]    dim;
  logic [RW-1:0]    dim_m1;
  logic [RW-1:0]    row;
  logic [AW-1:0]    col;
  logic [RW-1:0]    col_ext;
  logic             col_zero;
  logic [RW-1:0]    er;
  logic [RW-1:0]    ec;
  pos_t             pos_next;
  logic [PIX_W-1:0] px_next;
  logic             accept;
  logic             cfg_wr;

  logic             s1_valid;
  pos_t             s1_pos;
  logic [PIX_W-1:0] s1_px;
  logic [AW-1:0]    s1_addr;
  logic             s1_fire;

  logic [PIX_W-1:0] up_col;
  logic [PIX_W-1:0] mid_col;
  logic             win_ready;
  logic             acc_valid;
  logic             acc_ready;
  acc_t             acc;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // Frame size register
  always_ff @(posedge clk) begin
    if (rst) begin
      dim    <= clamp_dim(DIM_W'(DIM_RESET));
      dim_m1 <= clamp_dim(DIM_W'(DIM_RESET)) - RW'(1);
    end else if (cfg_wr) begin
      dim    <= clamp_dim(cfg_data);
      dim_m1 <= clamp_dim(cfg_data) - RW'(1);
    end
  end

  // Output position and neighbor flags for the incoming item
  assign col_ext  = RW'(col);
  assign col_zero = (col == '0);
  assign er       = col_zero ? row - RW'(2) : row - RW'(1);
  assign ec       = col_zero ? dim_m1 : col_ext - RW'(1);

  always_comb begin
    pos_next.produce = col_zero ? (row >= RW'(2)) : (row != '0);
    pos_next.top     = (er != '0);
    pos_next.bot     = (er != dim_m1);
    pos_next.left    = (ec != '0);
    pos_next.right   = !col_zero;
    pos_next.last    = (er == dim_m1) && (ec == dim_m1);
    pos_next.row     = COORD_W'(er);
    pos_next.col     = COORD_W'(ec);
  end

  // Drain items and items past the frame enter as black
  assign px_next = (!s_axis_tuser[0] && (row < dim)) ? s_axis_tdata[PIX_W-1:0] : '0;

  // Input position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (cfg_wr) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (row == dim + RW'(1)) begin
        row <= '0;
        col <= '0;
      end else if (col_ext + RW'(1) == dim) begin
        row <= row + RW'(1);
        col <= '0;
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // Input register stage
  assign s1_fire       = s1_valid && (!s1_pos.produce || win_ready);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos  <= pos_next;
      s1_px   <= px_next;
      s1_addr <= col;
    end
  end

  bf3_line_buf #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_px   (s1_px),
    .up_col  (up_col),
    .mid_col (mid_col)
  );

  bf3_window u_window (
    .clk        (clk),
    .rst        (rst),
    .shift      (s1_fire),
    .load       (s1_fire && s1_pos.produce),
    .load_ready (win_ready),
    .up_col     (up_col),
    .mid_col    (mid_col),
    .px         (s1_px),
    .pos        (s1_pos),
    .acc_valid  (acc_valid),
    .acc_ready  (acc_ready),
    .acc        (acc)
  );

  bf3_mean u_mean (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (acc_valid),
    .in_ready      (acc_ready),
    .acc           (acc),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ test/box_filter_3x3_edge_clipped_tb.sv @@
`timescale 1ns / 1ps

module box_filter_3x3_edge_clipped_tb;
  import bf3_pkg::*;

  localparam int MAX_DIM      = MAX_DIM_DEFAULT;
  localparam int DRAIN_CYCLES = 10;
  localparam int RX_HOLD      = 300;       // long receiver hold-off
  localparam int END_WAIT     = 50000;
  localparam int RANDOM_ITEMS = 260;

  // Kinds of input transaction
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_kind_t;

  // One averaged output pixel
  typedef struct packed {
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } mean_px_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DIM_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // red_in, green_in, blue_in
  logic [0:0]             s_axis_tuser = '0;   // req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // red, green, blue, out_row, out_col
  logic                   m_axis_tlast;        // last_of_frame

  // Expected averaged pixels, oldest first
  mean_px_t expected_means[$];

  // Filter state mirrored in the testbench
  logic [PIX_W-1:0] upper_row_mem [MAX_DIM];
  logic [PIX_W-1:0] middle_row_mem[MAX_DIM];
  logic [PIX_W-1:0] win_px[9];
  int               cur_dim;
  int               in_row;
  int               in_col;

  // Run bookkeeping
  int error_count   = 0;
  int items_sent    = 0;
  int means_checked = 0;
  int tx_gap_max    = 11;
  int tx_next_gap   = 0;
  bit tx_valid_up   = 1'b0;
  int rx_gap_max    = 11;
  int rx_hold_seq   = 0;

  box_filter_3x3_edge_clipped #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_filter_state();
    for (int i = 0; i < MAX_DIM; i++) begin
      upper_row_mem[i]  = '0;
      middle_row_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_px[i] = '0;
    cur_dim = DIM_RESET;
    in_row  = 0;
    in_col  = 0;
  endfunction

  // 0 behaves as 1, anything above MAX_DIM as MAX_DIM
  function automatic int active_dim();
    if (cur_dim == 0) return 1;
    if (cur_dim > MAX_DIM) return MAX_DIM;
    return cur_dim;
  endfunction

  function automatic void shift_window(int col, logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    up  = upper_row_mem[col];
    mid = middle_row_mem[col];
    for (int r = 0; r < 3; r++) begin
      win_px[r*3]   = win_px[r*3+1];
      win_px[r*3+1] = win_px[r*3+2];
    end
    win_px[2] = up;
    win_px[5] = mid;
    win_px[8] = px;
    upper_row_mem[col]  = mid;
    middle_row_mem[col] = px;
  endfunction

  // Mean of the in-frame neighbors of (er, ec); window column base holds ec
  function automatic mean_px_t window_mean(int er, int ec, int n, int base);
    int unsigned sr, sg, sb, cnt;
    int          rr, cc, wc;
    logic [PIX_W-1:0] p;
    mean_px_t    m;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = er + dr;
        cc = ec + dc;
        wc = base + dc;
        if (rr >= 0 && rr < n && cc >= 0 && cc < n && wc >= 0 && wc <= 2) begin
          p   = win_px[(dr + 1) * 3 + wc];
          sr += p[CH_W-1:0];
          sg += p[2*CH_W-1:CH_W];
          sb += p[3*CH_W-1:2*CH_W];
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    m.red   = CH_W'(sr / cnt);
    m.green = CH_W'(sg / cnt);
    m.blue  = CH_W'(sb / cnt);
    m.row   = COORD_W'(er);
    m.col   = COORD_W'(ec);
    m.last  = (er == n - 1 && ec == n - 1);
    return m;
  endfunction

  // Advance the filter by one accepted item; returns 1 when a pixel is due
  function automatic bit filter_pixel_item(req_kind_t kind, logic [PIX_W-1:0] pix,
                                           output mean_px_t m);
    int n, er;
    logic [PIX_W-1:0] px;
    bit made;
    n    = active_dim();
    made = 1'b0;
    if (in_col >= n || in_row > n + 1) begin
      in_row = 0;
      in_col = 0;
    end
    // drains inside the frame are black, pixels during the flush are ignored
    px = (kind == REQ_PIXEL && in_row < n) ? pix : '0;
    if (in_col == 0) begin
      er = in_row - 2;
      if (er >= 0) begin
        m    = window_mean(er, n - 1, n, 2);
        made = 1'b1;
      end
      shift_window(0, px);
    end else begin
      shift_window(in_col, px);
      er = in_row - 1;
      if (er >= 0) begin
        m    = window_mean(er, in_col - 1, n, 1);
        made = 1'b1;
      end
    end
    if (in_row == n + 1) begin
      in_row = 0;
      in_col = 0;
    end else begin
      in_col++;
      if (in_col >= n) begin
        in_col = 0;
        in_row++;
      end
    end
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_error($sformatf("%s of result %0d: got %0h, expected %0h",
                             name, means_checked, got, want));
  endtask

  // Receiver ready: random stalls after each transaction, plus requested holds
  initial begin : drive_rx_ready
    int rx_wait;
    int rx_hold_left;
    int rx_hold_seen;
    rx_wait      = 0;
    rx_hold_left = 0;
    rx_hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_seq != rx_hold_seen) begin
        rx_hold_seen = rx_hold_seq;
        rx_hold_left = RX_HOLD;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready) begin
        if (m_axis_tvalid) begin
          rx_wait = $urandom_range(0, rx_gap_max);
          if (rx_wait != 0) m_axis_tready <= 1'b0;
        end
      end else begin
        if (rx_wait != 0) rx_wait--;
        if (rx_wait == 0) m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest expected pixel
  always @(posedge clk) begin : check_means
    mean_px_t got;
    mean_px_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.red   = m_axis_tdata[0 +: CH_W];
      got.green = m_axis_tdata[CH_W +: CH_W];
      got.blue  = m_axis_tdata[2*CH_W +: CH_W];
      got.row   = m_axis_tdata[PIX_W +: COORD_W];
      got.col   = m_axis_tdata[PIX_W + COORD_W +: COORD_W];
      got.last  = m_axis_tlast;
      if (expected_means.size() == 0) begin
        report_error($sformatf("unexpected result at (%0d,%0d)", got.row, got.col));
      end else begin
        want = expected_means.pop_front();
        check_field("red",   got.red,   want.red);
        check_field("green", got.green, want.green);
        check_field("blue",  got.blue,  want.blue);
        check_field("row",   got.row,   want.row);
        check_field("col",   got.col,   want.col);
        check_field("last",  got.last,  want.last);
      end
      means_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  task automatic tx_stop();
    if (tx_valid_up) begin
      s_axis_tvalid <= 1'b0;
      tx_valid_up = 1'b0;
    end
  endtask

  task automatic send_item(req_kind_t kind, logic [PIX_W-1:0] px);
    mean_px_t m;
    repeat (tx_next_gap) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= kind;
    tx_valid_up = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (filter_pixel_item(kind, px, m)) expected_means.push_back(m);
    items_sent++;
    // valid stays high when the next item follows without a gap
    tx_next_gap = $urandom_range(0, tx_gap_max);
    if (tx_next_gap != 0) tx_stop();
  endtask

  // Source quiet, every pixel back, pipeline empty
  task automatic wait_for_idle();
    tx_stop();
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(int dim);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= DIM_W'(dim);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // a write also restarts the frame
    cur_dim = dim;
    in_row  = 0;
    in_col  = 0;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  function automatic int frame_items(int n);
    return n * n + n + 1;
  endfunction

  // Items first .. first+count-1 of an n x n frame with its flush
  task automatic send_frame(int n, int first, int count, int drain_pct);
    req_kind_t kind;
    for (int k = first; k < first + count; k++) begin
      if (k < n * n)
        kind = ($urandom_range(0, 99) < drain_pct) ? REQ_DRAIN : REQ_PIXEL;
      else
        kind = $urandom_range(0, 1) ? REQ_DRAIN : REQ_PIXEL;
      send_item(kind, rand_pixel());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Start of a frame at the reset size, before any write
  task automatic test_reset_dim();
    tx_gap_max = 0;
    send_frame(DIM_RESET, 0, DIM_RESET + 3, 0);
    wait_for_idle();
  endtask

  // Full-scale sums, every neighbor count, black drains, ignored flush pixels
  task automatic test_directed();
    tx_gap_max = 2;
    write_dim(3);
    repeat (9) send_item(REQ_PIXEL, '1);
    repeat (4) send_item(REQ_DRAIN, '0);
    write_dim(2);
    send_item(REQ_PIXEL, '0);
    send_item(REQ_DRAIN, '1);
    send_item(REQ_PIXEL, {16'hFFFF, 16'h8000, 16'h0001});
    send_item(REQ_PIXEL, '1);
    repeat (3) send_item(REQ_PIXEL, '1);
    // zero size behaves as a 1x1 frame
    write_dim(0);
    send_item(REQ_PIXEL, 48'h1234_5678_9ABC);
    send_item(REQ_PIXEL, '1);
    send_item(REQ_DRAIN, '1);
  endtask

  // Random small frames, back to back, some cut short by a size change
  task automatic test_random_frames();
    int start_items, dim, n, reps, pick;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       dim = 0;
      else if (pick < 65) dim = $urandom_range(1, 5);
      else if (pick < 95) dim = $urandom_range(6, 10);
      else                dim = $urandom_range(11, 16);
      n = (dim == 0) ? 1 : dim;
      write_dim(dim);
      reps = $urandom_range(1, 3);
      for (int f = 0; f < reps; f++) begin
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
        rx_gap_max <= ($urandom_range(0, 3) == 0) ? 0 : 11;
        if ($urandom_range(0, 9) == 0 && frame_items(n) > 1) begin
          send_frame(n, 0, $urandom_range(1, frame_items(n) - 1), 5);
          break;
        end
        send_frame(n, 0, frame_items(n), 5);
      end
    end
    rx_gap_max <= 11;
  endtask

  // Receiver holds off while the source streams, so the input stalls
  task automatic test_backpressure();
    write_dim(10);
    tx_gap_max = 0;
    rx_hold_seq <= rx_hold_seq + 1;
    send_frame(10, 0, frame_items(10), 0);
    tx_gap_max = 11;
  endtask

  // Source pauses mid-frame until the result stream has caught up
  task automatic test_source_pause();
    write_dim(5);
    send_frame(5, 0, 12, 0);
    wait_for_idle();
    send_frame(5, 12, frame_items(5) - 12, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    int spin;
    clear_filter_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_dim();
    test_directed();
    test_random_frames();
    test_backpressure();
    test_source_pause();

    tx_stop();
    for (spin = 0; spin < END_WAIT && expected_means.size() != 0; spin++)
      @(posedge clk);
    if (expected_means.size() != 0)
      report_error($sformatf("%0d pixels never came out", expected_means.size()));
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input transactions, checked %0d filtered pixels;",
             items_sent, means_checked);
    $display("reset size 512, sizes 0 to 16, drains, restarts, long hold-off, source pause.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
